// File: src/pgpw_pkg.sv
// ----------------------------------------------------------------------------
// pgpw_pkg
// Shared types and constants for the palette gradient pixel writer.
// ----------------------------------------------------------------------------
`default_nettype none

package pgpw_pkg;

    // request opcodes carried in s_axis_tuser
    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_DIRECT   = 2'd1,
        OP_INDEXED  = 2'd2,
        OP_GRADIENT = 2'd3
    } opcode_t;

    // configuration register indexes
    typedef enum logic {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_PALETTE_SIZE = 1'b1
    } cfg_index_t;

    localparam int POS_W      = 12;
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 3 * CHAN_W;
    localparam int FRAC_W     = 16;
    localparam int OFFSET_W   = 26;
    localparam int WIDTH_W    = 13;
    localparam int SIZE_W     = 9;
    localparam int CFG_DATA_W = 13;

    // per-pixel control handed from the front end to the read stage
    typedef struct packed {
        logic                  direct;   // pass the request colour through
        logic                  err;      // indexed lookup beyond the palette
        logic [FRAC_W-1:0]     frac;     // blend weight of the upper entry
        logic [RGB_W-1:0]      rgb;      // request colour, {r, g, b}
        logic [OFFSET_W-1:0]   base;     // y * width + x, in pixels
    } pix_ctl_t;

endpackage : pgpw_pkg

`default_nettype wire

// File: src/pgpw_ram.sv
// ----------------------------------------------------------------------------
// pgpw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pgpw_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : pgpw_ram

`default_nettype wire

// File: src/pgpw_front.sv
// ----------------------------------------------------------------------------
// pgpw_front
// Request decode: palette write enable, read addresses, blend weight,
// index check and the pixel position in the framebuffer.
// ----------------------------------------------------------------------------
`default_nettype none

module pgpw_front
    import pgpw_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic [1:0]                       opcode,
    input  wire logic [POS_W-1:0]                 pos_x,
    input  wire logic [POS_W-1:0]                 pos_y,
    input  wire logic [7:0]                       entry_index,
    input  wire logic [FRAC_W-1:0]                shade_value,
    input  wire logic [RGB_W-1:0]                 in_rgb,
    input  wire logic [WIDTH_W-1:0]               width_eff,
    input  wire logic [SIZE_W-1:0]                size_eff,
    output logic                                  pal_wr_ok,
    output logic      [$clog2(PALETTE_DEPTH)-1:0] wr_addr,
    output logic      [$clog2(PALETTE_DEPTH)-1:0] rd_addr_lo,
    output logic      [$clog2(PALETTE_DEPTH)-1:0] rd_addr_hi,
    output pix_ctl_t                              ctl
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic [2*POS_W:0]            yw;
    logic [FRAC_W+SIZE_W-1:0]    scaled;
    logic [SIZE_W-1:0]           grad_idx;
    logic [FRAC_W-1:0]           grad_frac;
    logic [SIZE_W-1:0]           size_m1;
    logic                        grad_last;
    logic                        idx_err;
    logic [FRAC_W-1:0]           frac_sel;
    opcode_t                     op;

    assign op = opcode_t'(opcode);

    // row start plus column
    assign yw       = pos_y * width_eff;
    assign ctl.base = OFFSET_W'(yw) + OFFSET_W'(pos_x);

    // gradient position scaled by the palette size
    assign scaled    = shade_value * size_eff;
    assign grad_idx  = scaled[FRAC_W+SIZE_W-1:FRAC_W];
    assign grad_frac = scaled[FRAC_W-1:0];
    assign size_m1   = size_eff - SIZE_W'(1);
    assign grad_last = (grad_idx >= size_m1);

    // index range checks
    assign idx_err   = ({1'b0, entry_index} >= size_eff);
    assign pal_wr_ok = (op == OP_WRITE) && (32'(entry_index) < 32'(PALETTE_DEPTH));
    assign wr_addr   = AW'(entry_index);

    // read addresses and blend weight
    always_comb begin
        rd_addr_lo = AW'(entry_index);
        rd_addr_hi = AW'(entry_index);
        frac_sel   = '0;
        case (op)
            OP_GRADIENT: begin
                if (grad_last) begin
                    rd_addr_lo = AW'(size_m1);
                    rd_addr_hi = AW'(size_m1);
                end else begin
                    rd_addr_lo = AW'(grad_idx);
                    rd_addr_hi = AW'(grad_idx + SIZE_W'(1));
                    frac_sel   = grad_frac;
                end
            end
            default: begin
            end
        endcase
    end

    assign ctl.frac   = frac_sel;
    assign ctl.direct = (op == OP_DIRECT);
    assign ctl.err    = (op == OP_INDEXED) && idx_err;
    assign ctl.rgb    = in_rgb;

endmodule : pgpw_front

`default_nettype wire

// File: src/pgpw_blend.sv
// ----------------------------------------------------------------------------
// pgpw_blend
// One colour channel blended between two palette entries, truncated.
// ----------------------------------------------------------------------------
`default_nettype none

module pgpw_blend
    import pgpw_pkg::*;
(
    input  wire logic [CHAN_W-1:0] chan_lo,
    input  wire logic [CHAN_W-1:0] chan_hi,
    input  wire logic [FRAC_W-1:0] frac,
    output logic      [CHAN_W-1:0] chan_out
);

    logic signed [CHAN_W:0]            diff;
    logic signed [FRAC_W:0]            frac_s;
    logic signed [CHAN_W+FRAC_W+1:0]   prod;
    logic signed [CHAN_W+FRAC_W+1:0]   acc;

    // lo*(1-f) + hi*f rewritten as lo + (hi-lo)*f
    assign diff     = $signed({1'b0, chan_hi}) - $signed({1'b0, chan_lo});
    assign frac_s   = $signed({1'b0, frac});
    assign prod     = diff * frac_s;
    assign acc      = $signed({2'b00, chan_lo, {FRAC_W{1'b0}}}) + prod;
    assign chan_out = acc[CHAN_W+FRAC_W-1:FRAC_W];

endmodule : pgpw_blend

`default_nettype wire

// File: src/palette_gradient_pixel_writer_unit.sv
// ----------------------------------------------------------------------------
// palette_gradient_pixel_writer_unit
// Palette lookup and gradient shading of pixel requests into framebuffer
// writes of a byte offset and an RGB triple.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_axis, one item per cycle while s_axis_tready is high;
//   the opcode rides in s_axis_tuser. A palette write updates the palette and
//   gives no output item; every other opcode gives exactly one item on m_axis.
//   An accepted item is registered with the palette read, then blended into
//   the output register that drives m_axis_tvalid. Throughput is one item per
//   clock while the output is not held, set by the two palette copies that each
//   serve one read per cycle (gradient pixels need the two neighboring entries).
//   A palette write commits at its accept edge, so a lookup accepted in the
//   next cycle already sees it.
//   Reset (aresetn low at a clock edge) empties the pipeline and loads the
//   register defaults; palette contents are not cleared, and reading an
//   entry never written gives an unspecified color.
//   When m_axis_tready is low the output item holds, the read stage fills,
//   and s_axis_tready drops until the output moves again.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_gradient_pixel_writer_unit
    import pgpw_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_WIDTH     = 4096
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request channel
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // pos_x[11:0], pos_y[23:12], entry_index[31:24], shade_value[47:32],
    // in_red[55:48], in_green[63:56], in_blue[71:64]
    input  wire logic [71:0]           s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]            s_axis_tuser,
    // pixel write channel
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // pixel_offset[25:0], out_red[33:26], out_green[41:34], out_blue[49:42],
    // zero fill[55:50]
    output logic      [55:0]           m_axis_tdata,
    // index_error[0]
    output logic      [0:0]            m_axis_tuser,
    // configuration writes
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int AW        = $clog2(PALETTE_DEPTH);
    localparam int SizeCap   = (PALETTE_DEPTH < 511) ? PALETTE_DEPTH : 511;
    localparam int WidthCap  = (MAX_WIDTH < 8191) ? MAX_WIDTH : 8191;
    localparam int SizeRst   = (SizeCap < 256) ? SizeCap : 256;
    localparam int WidthRst  = (WidthCap < 640) ? WidthCap : 640;
    localparam logic [SIZE_W-1:0]  SIZE_CAP  = SIZE_W'(SizeCap);
    localparam logic [WIDTH_W-1:0] WIDTH_CAP = WIDTH_W'(WidthCap);

    logic [WIDTH_W-1:0] width_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [WIDTH_W-1:0] width_next;
    logic [SIZE_W-1:0]  size_next;

    logic               in_accept;
    logic               adv_out;
    logic               pal_wr_ok;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr_lo;
    logic [AW-1:0]      rd_addr_hi;
    pix_ctl_t           front_ctl;
    logic [RGB_W-1:0]   entry_lo;
    logic [RGB_W-1:0]   entry_hi;
    logic [RGB_W-1:0]   blend_rgb;
    logic [RGB_W-1:0]   pix_rgb;
    logic [OFFSET_W-1:0] pix_offset;

    logic               valid1_reg;
    pix_ctl_t           ctl1_reg;
    logic               valid2_reg;
    logic [OFFSET_W-1:0] offset2_reg;
    logic [RGB_W-1:0]   rgb2_reg;
    logic               err2_reg;

    // configuration values, clamped on write
    always_comb begin
        width_next = (cfg_wdata > WIDTH_CAP) ? WIDTH_CAP : cfg_wdata;
        size_next  = cfg_wdata[SIZE_W-1:0];
        if (size_next == '0) begin
            size_next = SIZE_W'(1);
        end else if (size_next > SIZE_CAP) begin
            size_next = SIZE_CAP;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_W'(WidthRst);
            size_reg  <= SIZE_W'(SizeRst);
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg <= width_next;
                CFG_PALETTE_SIZE: size_reg  <= size_next;
                default: begin
                end
            endcase
        end
    end

    // handshake: output register frees first, read stage follows
    assign adv_out       = !valid2_reg || m_axis_tready;
    assign s_axis_tready = !valid1_reg || adv_out;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // request decode
    pgpw_front #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_front (
        .opcode      (s_axis_tuser),
        .pos_x       (s_axis_tdata[11:0]),
        .pos_y       (s_axis_tdata[23:12]),
        .entry_index (s_axis_tdata[31:24]),
        .shade_value (s_axis_tdata[47:32]),
        .in_rgb      ({s_axis_tdata[55:48], s_axis_tdata[63:56], s_axis_tdata[71:64]}),
        .width_eff   (width_reg),
        .size_eff    (size_reg),
        .pal_wr_ok   (pal_wr_ok),
        .wr_addr     (wr_addr),
        .rd_addr_lo  (rd_addr_lo),
        .rd_addr_hi  (rd_addr_hi),
        .ctl         (front_ctl)
    );

    // two palette copies, written together, one read each
    pgpw_ram #(
        .WIDTH(RGB_W),
        .DEPTH(PALETTE_DEPTH)
    ) u_pal_lo (
        .aclk    (aclk),
        .wr_en   (in_accept && pal_wr_ok),
        .wr_addr (wr_addr),
        .wr_data (front_ctl.rgb),
        .rd_en   (in_accept),
        .rd_addr (rd_addr_lo),
        .rd_data (entry_lo)
    );

    pgpw_ram #(
        .WIDTH(RGB_W),
        .DEPTH(PALETTE_DEPTH)
    ) u_pal_hi (
        .aclk    (aclk),
        .wr_en   (in_accept && pal_wr_ok),
        .wr_addr (wr_addr),
        .wr_data (front_ctl.rgb),
        .rd_en   (in_accept),
        .rd_addr (rd_addr_hi),
        .rd_data (entry_hi)
    );

    // read stage: palette data arrives, control waits alongside
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid1_reg <= in_accept && (opcode_t'(s_axis_tuser) != OP_WRITE);
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            ctl1_reg <= front_ctl;
        end
    end

    // per-channel blend
    for (genvar ch = 0; ch < 3; ch++) begin : g_chan
        pgpw_blend u_blend (
            .chan_lo  (entry_lo[ch*CHAN_W +: CHAN_W]),
            .chan_hi  (entry_hi[ch*CHAN_W +: CHAN_W]),
            .frac     (ctl1_reg.frac),
            .chan_out (blend_rgb[ch*CHAN_W +: CHAN_W])
        );
    end

    // color select and byte offset (three bytes per pixel)
    always_comb begin
        if (ctl1_reg.direct) begin
            pix_rgb = ctl1_reg.rgb;
        end else if (ctl1_reg.err) begin
            pix_rgb = '0;
        end else begin
            pix_rgb = blend_rgb;
        end
    end

    assign pix_offset = ctl1_reg.base + {ctl1_reg.base[OFFSET_W-2:0], 1'b0};

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (adv_out) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_out && valid1_reg) begin
            offset2_reg <= pix_offset;
            rgb2_reg    <= pix_rgb;
            err2_reg    <= ctl1_reg.err;
        end
    end

    assign m_axis_tvalid   = valid2_reg;
    assign m_axis_tdata    = {6'b0, rgb2_reg[7:0], rgb2_reg[15:8], rgb2_reg[23:16],
                              offset2_reg};
    assign m_axis_tuser[0] = err2_reg;

    // a palette write never produces an output item
    a_write_no_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && (opcode_t'(s_axis_tuser) == OP_WRITE) |=> !valid1_reg)
        else $error("palette write entered the read stage");

    // a pixel request always reaches the read stage
    a_pixel_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && (opcode_t'(s_axis_tuser) != OP_WRITE) |=> valid1_reg)
        else $error("pixel request lost at the read stage");

    // palette data of a held item must not be overwritten by a new read
    a_read_held: assert property (@(posedge aclk) disable iff (!aresetn)
        valid1_reg && !adv_out |=> $stable(entry_lo) && $stable(entry_hi))
        else $error("palette read data changed under a stalled item");

    // an index error always gives black
    a_err_black: assert property (@(posedge aclk) disable iff (!aresetn)
        valid2_reg && err2_reg |-> (rgb2_reg == '0))
        else $error("index error with nonzero color");

endmodule : palette_gradient_pixel_writer_unit

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the palette gradient pixel writer. A queue of
// requests feeds a stream driver with random gaps, a monitor with random
// back-pressure checks every framebuffer write against a local model of
// the palette, the offset math and the gradient blend. The run steps
// through several width and palette-size settings, extremes included.
// ----------------------------------------------------------------------------

module tb;
    import pgpw_pkg::*;

    localparam int PAL_DEPTH   = 256;
    localparam int MAX_IMG_W   = 4096;
    localparam int PIXEL_BYTES = 3;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 3000;

    // one request item as the bench sees it
    typedef struct {
        opcode_t            op;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [7:0]         idx;
        logic [FRAC_W-1:0]  shade;
        logic [RGB_W-1:0]   rgb;     // {r, g, b}
    } pix_req_t;

    // one framebuffer write the block should produce
    typedef struct {
        logic [OFFSET_W-1:0] offset;
        logic [RGB_W-1:0]    rgb;    // {r, g, b}
        logic                err;
    } fb_write_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    wire logic             s_axis_tready;
    logic [71:0]           s_axis_tdata = '0;
    logic [1:0]            s_axis_tuser = '0;
    wire logic             m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    wire logic [55:0]      m_axis_tdata;
    wire logic [0:0]       m_axis_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // model state
    logic [RGB_W-1:0]      palette_copy [PAL_DEPTH];
    logic [WIDTH_W-1:0]    cfg_width = 13'd640;
    logic [SIZE_W-1:0]     cfg_size = 9'd256;

    pix_req_t              pending_reqs [$];
    fb_write_t             expected_writes [$];
    pix_req_t              offered;
    bit                    source_busy = 1'b0;
    int unsigned           src_idle_pct = 29;
    int unsigned           snk_idle_pct = 29;
    bit                    hold_req = 1'b0;
    int unsigned           hold_cnt = 0;
    int unsigned           quiet_cycles = 0;
    int unsigned           errors = 0;

    palette_gradient_pixel_writer_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // 125 MHz clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // palette size as the block uses it: zero acts as one, clamp to depth
    function automatic int unsigned live_palette_size();
        if (cfg_size == 0) return 1;
        if (cfg_size > PAL_DEPTH) return PAL_DEPTH;
        return cfg_size;
    endfunction

    // update the palette model or queue the write this request produces
    task automatic apply_request(input pix_req_t rq);
        fb_write_t        want;
        longint unsigned  lin;
        int unsigned      w, sz, s, seg, frac;
        logic [RGB_W-1:0] lo, hi;
        if (rq.op == OP_WRITE) begin
            palette_copy[rq.idx] = rq.rgb;
            return;
        end
        w = (cfg_width > MAX_IMG_W) ? MAX_IMG_W : cfg_width;
        sz = live_palette_size();
        lin = rq.y * w + rq.x;
        want.offset = OFFSET_W'(lin * PIXEL_BYTES);
        want.rgb = rq.rgb;
        want.err = 1'b0;
        case (rq.op)
            OP_INDEXED: begin
                if (rq.idx >= sz) begin
                    want.err = 1'b1;
                    want.rgb = '0;
                end else begin
                    want.rgb = palette_copy[rq.idx];
                end
            end
            OP_GRADIENT: begin
                s = rq.shade * sz;
                seg = s >> 16;
                frac = s & 32'hFFFF;
                if (seg >= sz - 1) begin
                    want.rgb = palette_copy[sz-1];
                end else begin
                    lo = palette_copy[seg];
                    hi = palette_copy[seg+1];
                    // truncating blend per channel
                    for (int ch = 0; ch < 3; ch++) begin
                        want.rgb[ch*CHAN_W +: CHAN_W] = CHAN_W'(
                            (lo[ch*CHAN_W +: CHAN_W] * (32'd65536 - frac)
                             + hi[ch*CHAN_W +: CHAN_W] * frac) >> 16);
                    end
                end
            end
            default: ;
        endcase
        expected_writes.push_back(want);
    endtask

    function automatic void check_field(input string field, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
        end
    endfunction

    // request driver
    always @(posedge aclk) begin : source
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(offered);
                source_busy = 1'b0;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    offered = pending_reqs.pop_front();
                    source_busy = 1'b1;
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {offered.rgb[7:0], offered.rgb[15:8], offered.rgb[23:16],
                                     offered.shade, offered.idx, offered.y, offered.x};
                    s_axis_tuser <= offered.op;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // pixel write monitor and back-pressure
    always @(posedge aclk) begin : sink
        fb_write_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected pixel write, offset %0d", m_axis_tdata[25:0]);
                    errors++;
                end else begin
                    want = expected_writes.pop_front();
                    check_field("pixel_offset", want.offset, m_axis_tdata[25:0]);
                    check_field("out_red", want.rgb[23:16], m_axis_tdata[33:26]);
                    check_field("out_green", want.rgb[15:8], m_axis_tdata[41:34]);
                    check_field("out_blue", want.rgb[7:0], m_axis_tdata[49:42]);
                    check_field("index_error", want.err, m_axis_tuser[0]);
                end
            end
            // one long hold-off so the block fills and stalls its input
            if (hold_req && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QUIET_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    task automatic push_req(input opcode_t op, input int unsigned x, input int unsigned y,
                            input int unsigned idx, input int unsigned shade,
                            input logic [RGB_W-1:0] rgb);
        pix_req_t rq;
        rq.op = op;
        rq.x = POS_W'(x);
        rq.y = POS_W'(y);
        rq.idx = 8'(idx);
        rq.shade = FRAC_W'(shade);
        rq.rgb = rgb;
        pending_reqs.push_back(rq);
    endtask

    // random request, indexed lookups biased into the live palette
    function automatic pix_req_t random_request();
        pix_req_t    rq;
        int unsigned pick;
        pick = $urandom_range(99);
        rq.op = (pick < 12) ? OP_WRITE : (pick < 30) ? OP_DIRECT :
                (pick < 62) ? OP_INDEXED : OP_GRADIENT;
        rq.x = POS_W'($urandom());
        rq.y = POS_W'($urandom());
        pick = $urandom_range(9);
        if (pick == 0) rq.x = '0;
        if (pick == 1) rq.x = '1;
        if (pick == 2) rq.y = '0;
        if (pick == 3) rq.y = '1;
        rq.idx = 8'($urandom());
        if (rq.op == OP_INDEXED && $urandom_range(3) != 0)
            rq.idx = 8'($urandom_range(live_palette_size() - 1));
        rq.shade = FRAC_W'($urandom());
        pick = $urandom_range(9);
        if (pick == 0) rq.shade = '0;
        if (pick == 1) rq.shade = '1;
        rq.rgb = RGB_W'($urandom());
        return rq;
    endfunction

    task automatic add_random(input int n);
        repeat (n) pending_reqs.push_back(random_request());
    endtask

    // wait until every queued item is taken and every write has come back
    task automatic drain();
        do @(posedge aclk);
        while (pending_reqs.size() != 0 || source_busy || expected_writes.size() != 0);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_IMAGE_WIDTH) cfg_width = WIDTH_W'(val);
        else cfg_size = SIZE_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // registers change only with the pipeline empty
    task automatic reconfigure(input int unsigned w, input int unsigned s);
        drain();
        repeat (4) @(posedge aclk);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_PALETTE_SIZE, CFG_DATA_W'(s));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // load every palette entry so no lookup reads an unwritten one
        for (int e = 0; e < PAL_DEPTH; e++) begin
            push_req(OP_WRITE, $urandom(), $urandom(), e, $urandom(),
                     (e == 0) ? 24'h000000 : (e == PAL_DEPTH - 1) ? 24'hFFFFFF
                                                                  : RGB_W'($urandom()));
        end

        // directed checks at reset settings
        push_req(OP_DIRECT, 0, 0, 0, 0, 24'h000000);
        push_req(OP_DIRECT, 4095, 4095, 255, 16'hFFFF, 24'hFFFFFF);
        push_req(OP_INDEXED, 1, 2, 0, 0, 24'hFFFFFF);
        push_req(OP_INDEXED, 3, 4, 255, 0, 24'h000000);
        push_req(OP_GRADIENT, 5, 6, 0, 16'h0000, 24'hA5A5A5);
        push_req(OP_GRADIENT, 7, 8, 0, 16'hFFFF, 24'h5A5A5A);
        push_req(OP_GRADIENT, 9, 10, 0, 16'h8000, 24'h000000);
        push_req(OP_GRADIENT, 11, 12, 0, 16'h0001, 24'h000000);
        // write followed at once by reads of the same entry
        push_req(OP_WRITE, 0, 0, 1, 0, 24'hFFFFFF);
        push_req(OP_GRADIENT, 13, 14, 0, 16'h00FF, 24'h000000);
        push_req(OP_INDEXED, 15, 16, 1, 0, 24'h000000);
        push_req(OP_WRITE, 0, 0, 255, 0, 24'h123456);
        push_req(OP_GRADIENT, 17, 18, 0, 16'hFFFF, 24'h000000);
        add_random(120);

        // one-entry palette: lookups past entry zero flag an error
        reconfigure(1, 1);
        push_req(OP_INDEXED, 4095, 4095, 0, 0, 24'hFFFFFF);
        push_req(OP_INDEXED, 1, 1, 1, 0, 24'hFFFFFF);
        push_req(OP_INDEXED, 2, 2, 255, 0, 24'hFFFFFF);
        push_req(OP_GRADIENT, 3, 3, 0, 16'hFFFF, 24'h000000);
        push_req(OP_GRADIENT, 4, 4, 0, 16'h0000, 24'h000000);
        add_random(120);

        // back to back with no gaps on either side
        reconfigure(MAX_IMG_W, 2);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        add_random(120);

        // width above the maximum clamps, size zero acts as one
        reconfigure(8191, 0);
        src_idle_pct = 29;
        snk_idle_pct = 29;
        add_random(120);

        // zero width, size above the depth clamps
        reconfigure(0, 511);
        add_random(120);

        // long receiver hold-off while requests keep coming
        reconfigure(13, 5);
        add_random(120);
        hold_req = 1'b1;

        reconfigure($urandom_range(1, 8191), $urandom_range(1, 511));
        add_random(120);
        reconfigure($urandom_range(1, 8191), $urandom_range(1, 511));
        add_random(120);
        reconfigure(640, PAL_DEPTH);
        add_random(120);

        drain();
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/pgpw_pkg.sv
src/pgpw_ram.sv
src/pgpw_front.sv
src/pgpw_blend.sv
src/palette_gradient_pixel_writer_unit.sv
verif/tb.sv
